>>> hw/rtl/image_name_normalizer_assert.svh
// assertion macros used by the checker file
`ifndef IMAGE_NAME_NORMALIZER_ASSERT_SVH
`define IMAGE_NAME_NORMALIZER_ASSERT_SVH

// same-cycle implication, sampled on the rising clock, off during reset
`define IMGNN_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("image name normalizer check failed");

// next-cycle implication, sampled on the rising clock, off during reset
`define IMGNN_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("image name normalizer check failed");

`endif

>>> hw/rtl/imgnn_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package imgnn_pkg;

    localparam int DATA_W     = 8;
    localparam int MAXLEN_W   = 11;
    localparam int MAX_RES    = 8;
    localparam int RES_CNT_W  = 4;
    localparam int RES_IDX_W  = 3;

    localparam logic [MAXLEN_W-1:0] MAXLEN_RESET = 11'd1024;
    localparam logic [MAXLEN_W-1:0] MAXLEN_TOP   = 11'd2047;

    // character codes
    localparam logic [DATA_W-1:0] CH_UPPER_A = 8'h41;
    localparam logic [DATA_W-1:0] CH_UPPER_Z = 8'h5A;
    localparam logic [DATA_W-1:0] CH_CASE    = 8'h20;
    localparam logic [DATA_W-1:0] CH_AMP     = 8'h26;
    localparam logic [DATA_W-1:0] CH_QUOTE   = 8'h22;
    localparam logic [DATA_W-1:0] CH_COLON   = 8'h3A;
    localparam logic [DATA_W-1:0] CH_DOT     = 8'h2E;
    localparam logic [DATA_W-1:0] CH_SPACE   = 8'h20;
    localparam logic [DATA_W-1:0] CH_TAB     = 8'h09;
    localparam logic [DATA_W-1:0] CH_NL      = 8'h0A;
    localparam logic [DATA_W-1:0] CH_HYPHEN  = 8'h2D;
    localparam logic [DATA_W-1:0] CH_UNDER   = 8'h5F;
    localparam logic [DATA_W-1:0] CH_LOWER_A = 8'h61;
    localparam logic [DATA_W-1:0] CH_LOWER_Q = 8'h71;

    localparam logic [2:0] PREFIX_LEN = 3'd5;
    localparam logic [2:0] AMP_LEN    = 3'd4;
    localparam logic [2:0] QUOT_LEN   = 3'd5;

    // pending entity match
    typedef enum logic [1:0] {
        EK_NONE,
        EK_AMPER,
        EK_AMP,
        EK_QUOT
    } ent_kind_t;

    // "file:"
    function automatic logic [DATA_W-1:0] prefix_char(input logic [2:0] idx);
        logic [DATA_W-1:0] ch;
        case (idx)
            3'd0:    ch = 8'h66;
            3'd1:    ch = 8'h69;
            3'd2:    ch = 8'h6C;
            3'd3:    ch = 8'h65;
            3'd4:    ch = 8'h3A;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // "amp;"
    function automatic logic [DATA_W-1:0] amp_char(input logic [1:0] idx);
        logic [DATA_W-1:0] ch;
        case (idx)
            2'd0:    ch = 8'h61;
            2'd1:    ch = 8'h6D;
            2'd2:    ch = 8'h70;
            2'd3:    ch = 8'h3B;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // "quot;"
    function automatic logic [DATA_W-1:0] quot_char(input logic [2:0] idx);
        logic [DATA_W-1:0] ch;
        case (idx)
            3'd0:    ch = 8'h71;
            3'd1:    ch = 8'h75;
            3'd2:    ch = 8'h6F;
            3'd3:    ch = 8'h74;
            3'd4:    ch = 8'h3B;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/image_name_normalizer.sv
// an accepted input beat passes through the pending result list and the output register
// throughput: 1 input beat per cycle while each byte yields at most one result and the
//   output is free; bytes released together share the single output port and stall input
// reset: aresetn synchronous active low; clears match state, byte count and
//   pending results, and sets max_out_len to 1024
`timescale 1ns / 1ps
`default_nettype none

module image_name_normalizer
    import imgnn_pkg::*;
#(
    parameter int BUFFER_BYTES = 1024
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    // input stream
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [DATA_W-1:0]   s_tdata,   // [7:0] name_byte
    input  wire logic                s_tlast,   // end_of_name
    // result stream
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [DATA_W-1:0]        m_tdata,   // [7:0] out_byte
    output logic                     m_tuser,   // [0] has_byte
    output logic                     m_tlast,   // run_last
    // configuration write
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [MAXLEN_W-1:0] cfg_data   // max_out_len
);

    localparam logic [MAXLEN_W-1:0] BUF_CAP =
        (BUFFER_BYTES > int'(MAXLEN_TOP)) ? MAXLEN_TOP : MAXLEN_W'(BUFFER_BYTES);

    // state
    logic [MAXLEN_W-1:0]  max_len_reg;
    logic [2:0]           pp_reg, pp_next;
    logic                 pd_reg, pd_next;
    ent_kind_t            ek_reg, ek_next;
    logic [2:0]           eh_reg, eh_next;
    logic [MAXLEN_W-1:0]  emitted_reg, emitted_next;

    // pending results of the last accepted byte
    logic [DATA_W-1:0]    job_byte_reg [MAX_RES];
    logic [RES_CNT_W-1:0] job_rem_reg;
    logic [RES_IDX_W-1:0] job_idx_reg;
    logic                 job_marker_reg;
    logic                 job_last_reg;

    // output register
    logic                 m_tvalid_reg;
    logic [DATA_W-1:0]    m_tdata_reg;
    logic                 m_tuser_reg;
    logic                 m_tlast_reg;

    logic                 out_free;
    logic                 move;
    logic                 accept;

    logic [DATA_W-1:0]    list [MAX_RES];
    logic [RES_CNT_W-1:0] cnt;
    logic [DATA_W-1:0]    lc;
    logic                 do_text;
    logic                 text_done;
    logic                 flush_now;
    logic [2:0]           pat_len;
    logic [DATA_W-1:0]    want;

    logic [MAXLEN_W-1:0]  size;
    logic [MAXLEN_W-1:0]  limit;
    logic [MAXLEN_W-1:0]  room;
    logic [RES_CNT_W-1:0] nemit;

    // handshake
    assign out_free  = !m_tvalid_reg || m_tready;
    assign move      = out_free && (job_rem_reg != '0);
    assign s_tready  = (job_rem_reg == '0) || ((job_rem_reg == RES_CNT_W'(1)) && out_free);
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    // per-byte normalization: next state and candidate result bytes
    always_comb begin
        pp_next   = pp_reg;
        pd_next   = pd_reg;
        ek_next   = ek_reg;
        eh_next   = eh_reg;
        cnt       = '0;
        do_text   = 1'b0;
        text_done = 1'b0;
        flush_now = 1'b0;
        pat_len   = AMP_LEN;
        want      = '0;
        for (int i = 0; i < MAX_RES; i++) begin
            list[i] = '0;
        end
        lc = ((s_tdata >= CH_UPPER_A) && (s_tdata <= CH_UPPER_Z)) ? (s_tdata | CH_CASE)
                                                                  : s_tdata;

        // leading prefix match
        if (!pd_reg) begin
            if ((pp_reg < PREFIX_LEN) && (lc == prefix_char(pp_reg))) begin
                if (pp_reg == PREFIX_LEN - 3'd1) begin
                    pp_next = '0;
                    pd_next = 1'b1;
                end else begin
                    pp_next = pp_reg + 3'd1;
                end
            end else begin
                for (int i = 0; i < 4; i++) begin
                    if (3'(i) < pp_reg) begin
                        list[cnt[RES_IDX_W-1:0]] = prefix_char(3'(i));
                        cnt = cnt + RES_CNT_W'(1);
                    end
                end
                pp_next = '0;
                pd_next = 1'b1;
                do_text = 1'b1;
            end
        end else begin
            do_text = 1'b1;
        end

        if (do_text) begin
            // entity match in progress
            case (ek_reg)
                EK_AMPER: begin
                    if (lc == CH_LOWER_A) begin
                        ek_next   = EK_AMP;
                        eh_next   = 3'd1;
                        text_done = 1'b1;
                    end else if (lc == CH_LOWER_Q) begin
                        ek_next   = EK_QUOT;
                        eh_next   = 3'd1;
                        text_done = 1'b1;
                    end else begin
                        flush_now = 1'b1;
                    end
                end
                EK_AMP, EK_QUOT: begin
                    pat_len = (ek_reg == EK_AMP) ? AMP_LEN : QUOT_LEN;
                    if (eh_reg >= pat_len) begin
                        flush_now = 1'b1;
                    end else begin
                        want = (ek_reg == EK_AMP) ? amp_char(eh_reg[1:0]) : quot_char(eh_reg);
                        if (lc == want) begin
                            if (eh_reg + 3'd1 == pat_len) begin
                                list[cnt[RES_IDX_W-1:0]] = (ek_reg == EK_AMP) ? CH_AMP
                                                                              : CH_QUOTE;
                                cnt     = cnt + RES_CNT_W'(1);
                                ek_next = EK_NONE;
                                eh_next = '0;
                            end else begin
                                eh_next = eh_reg + 3'd1;
                            end
                            text_done = 1'b1;
                        end else begin
                            flush_now = 1'b1;
                        end
                    end
                end
                default: ;
            endcase

            // replay a failed entity as text
            if (flush_now) begin
                list[cnt[RES_IDX_W-1:0]] = CH_AMP;
                cnt = cnt + RES_CNT_W'(1);
                for (int i = 0; i < 5; i++) begin
                    if (3'(i) < eh_reg) begin
                        list[cnt[RES_IDX_W-1:0]] = (ek_reg == EK_AMP) ? amp_char(2'(i))
                                                                      : quot_char(3'(i));
                        cnt = cnt + RES_CNT_W'(1);
                    end
                end
                ek_next = EK_NONE;
                eh_next = '0;
            end

            // plain character handling
            if (!text_done) begin
                if (s_tdata == CH_AMP) begin
                    ek_next = EK_AMPER;
                    eh_next = '0;
                end else if (s_tdata == CH_COLON) begin
                    list[cnt[RES_IDX_W-1:0]] = CH_DOT;
                    cnt = cnt + RES_CNT_W'(1);
                end else if (!((s_tdata == CH_SPACE) || (s_tdata == CH_TAB) ||
                               (s_tdata == CH_NL) || (s_tdata == CH_HYPHEN) ||
                               (s_tdata == CH_UNDER))) begin
                    list[cnt[RES_IDX_W-1:0]] = lc;
                    cnt = cnt + RES_CNT_W'(1);
                end
            end
        end

        // end of name: release everything held, then start over
        if (s_tlast) begin
            if (!pd_next) begin
                for (int i = 0; i < 4; i++) begin
                    if (3'(i) < pp_next) begin
                        list[cnt[RES_IDX_W-1:0]] = prefix_char(3'(i));
                        cnt = cnt + RES_CNT_W'(1);
                    end
                end
            end
            if (ek_next != EK_NONE) begin
                list[cnt[RES_IDX_W-1:0]] = CH_AMP;
                cnt = cnt + RES_CNT_W'(1);
                for (int i = 0; i < 5; i++) begin
                    if (3'(i) < eh_next) begin
                        list[cnt[RES_IDX_W-1:0]] = (ek_next == EK_AMP) ? amp_char(2'(i))
                                                                       : quot_char(3'(i));
                        cnt = cnt + RES_CNT_W'(1);
                    end
                end
            end
            pp_next = '0;
            pd_next = 1'b0;
            ek_next = EK_NONE;
            eh_next = '0;
        end
    end

    // output length limit
    always_comb begin
        size  = (max_len_reg > BUF_CAP) ? BUF_CAP : max_len_reg;
        limit = (size == '0) ? '0 : size - MAXLEN_W'(1);
        room  = (emitted_reg >= limit) ? '0 : limit - emitted_reg;
        nemit = (room < MAXLEN_W'(cnt)) ? room[RES_CNT_W-1:0] : cnt;
        emitted_next = s_tlast ? '0 : emitted_reg + MAXLEN_W'(nemit);
    end

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_len_reg <= MAXLEN_RESET;
        end else if (cfg_valid && cfg_ready) begin
            max_len_reg <= cfg_data;
        end
    end

    // match state, updated per accepted beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pp_reg      <= '0;
            pd_reg      <= 1'b0;
            ek_reg      <= EK_NONE;
            eh_reg      <= '0;
            emitted_reg <= '0;
        end else if (accept) begin
            pp_reg      <= pp_next;
            pd_reg      <= pd_next;
            ek_reg      <= ek_next;
            eh_reg      <= eh_next;
            emitted_reg <= emitted_next;
        end
    end

    // pending result list
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            job_rem_reg <= '0;
            job_idx_reg <= '0;
        end else if (accept) begin
            job_rem_reg <= (s_tlast && (nemit == '0)) ? RES_CNT_W'(1) : nemit;
            job_idx_reg <= '0;
        end else if (move) begin
            job_rem_reg <= job_rem_reg - RES_CNT_W'(1);
            job_idx_reg <= job_idx_reg + RES_IDX_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            job_byte_reg   <= list;
            job_marker_reg <= s_tlast && (nemit == '0);
            job_last_reg   <= s_tlast;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (move) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (move) begin
            m_tdata_reg <= job_marker_reg ? '0 : job_byte_reg[job_idx_reg];
            m_tuser_reg <= !job_marker_reg;
            m_tlast_reg <= job_last_reg && (job_rem_reg == RES_CNT_W'(1));
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/imgnn_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "image_name_normalizer_assert.svh"

module imgnn_checker
    import imgnn_pkg::*;
(
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                s_tvalid,
    input wire logic                s_tready,
    input wire logic [DATA_W-1:0]   s_tdata,
    input wire logic                s_tlast,
    input wire logic                m_tvalid,
    input wire logic                m_tready,
    input wire logic [DATA_W-1:0]   m_tdata,
    input wire logic                m_tuser,
    input wire logic                m_tlast,
    input wire logic                cfg_valid,
    input wire logic                cfg_ready,
    input wire logic [MAXLEN_W-1:0] cfg_data
);

    // a stalled result beat holds
    `IMGNN_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))

    // the end marker only closes a name and carries no byte
    `IMGNN_ASSERT_NOW(a_marker_last, m_tvalid && !m_tuser, m_tlast && (m_tdata == '0))

    // normalized bytes are never capitals or colons
    `IMGNN_ASSERT_NOW(a_out_normal, m_tvalid && m_tuser, !((m_tdata >= CH_UPPER_A) && (m_tdata <= CH_UPPER_Z)) && (m_tdata != CH_COLON))

    // input stalls only while results are being drained
    `IMGNN_ASSERT_NEXT(a_stall_drains, !s_tready, m_tvalid)

endmodule

bind image_name_normalizer imgnn_checker u_imgnn_checker (.*);

`default_nettype wire
